// ===== design/bpa_pkg.sv =====
// Shared constants, command and status codes, and controller/datapath
// interface structs for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

    // Map geometry
    localparam int PAGE_COUNT    = 65536;
    localparam int MAP_WORD_BITS = 64;
    localparam int PAGE_W        = 16;   // page index field width
    localparam int CNT_W         = 17;   // counts and limit width
    localparam int LIMIT_MAX     = (PAGE_COUNT < 65536) ? PAGE_COUNT : 65536;
    localparam int MAP_WORDS     = (LIMIT_MAX + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);
    localparam int WADDR_W       = PAGE_W - BIT_W;
    localparam int RESERVE_MAX   = 65536;

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 72;

    // Command codes
    localparam logic [2:0] CMD_ALLOC     = 3'd0;
    localparam logic [2:0] CMD_FREE      = 3'd1;
    localparam logic [2:0] CMD_LOCK      = 3'd2;
    localparam logic [2:0] CMD_RESERVE   = 3'd3;
    localparam logic [2:0] CMD_UNRESERVE = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_OOM      = 2'd1;
    localparam logic [1:0] STAT_NOCHANGE = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic clear;     // clearing pass: write zero word, step address
        logic accept;    // capture a command
        logic eval;      // map word is in the read register
        logic load_out;  // move the result into the output register
    } bpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done; // last map word is being cleared
        logic scan_more;  // allocate found nothing here, next word is in range
        logic out_busy;   // output register holds a result not yet taken
    } bpa_stat_t;

endpackage

// ===== design/bpa_ctrl.sv =====
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg (command/status structs).
module bpa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output bpa_pkg::bpa_cmd_t   ctl,
    input  bpa_pkg::bpa_stat_t  sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        ctl.clear    = 1'b0;
        ctl.accept   = 1'b0;
        ctl.eval     = 1'b0;
        ctl.load_out = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ctl.clear = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    ctl.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                ctl.eval = 1'b1;
                if (!sts.scan_more) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!sts.out_busy) begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

// ===== design/bpa_dpath.sv =====
// Datapath of the bitmap page allocator: used-map memory, scan logic,
// hint and page counters, and the result register.
// Depends on bpa_pkg (constants, codes, structs).
module bpa_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bpa_pkg::bpa_cmd_t                  ctl,
    output bpa_pkg::bpa_stat_t                 sts,
    input  logic [2:0]                         in_command,
    input  logic [bpa_pkg::PAGE_W-1:0]         in_page,
    input  logic [bpa_pkg::CNT_W-1:0]          limit,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [bpa_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int WB = bpa_pkg::MAP_WORD_BITS;
    localparam int BW = bpa_pkg::BIT_W;
    localparam int AW = bpa_pkg::WADDR_W;
    localparam int PW = bpa_pkg::PAGE_W;
    localparam int CW = bpa_pkg::CNT_W;
    localparam int LW = CW - BW;            // limit in words, with carry room

    // Used map, one bit per page
    logic [WB-1:0] map_mem [bpa_pkg::MAP_WORDS];
    logic [WB-1:0] rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [WB-1:0] mem_wdata;

    // Command and scan state
    logic [2:0]    cmd_reg;
    logic [PW-1:0] page_reg;
    logic [AW-1:0] word_reg;
    logic          first_reg;
    logic [PW-1:0] hint_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] resv_reg;
    logic [1:0]    status_reg;
    logic [PW-1:0] result_reg;

    // Output register
    logic          m_tvalid_reg;
    logic [1:0]    o_status_reg;
    logic [PW-1:0] o_page_reg;
    logic [CW-1:0] o_free_reg;
    logic [CW-1:0] o_used_reg;
    logic [CW-1:0] o_resv_reg;

    // Evaluation signals
    logic [BW-1:0] bit_sel;
    logic          page_bit;
    logic [WB-1:0] page_onehot;
    logic          in_range;
    logic [LW-1:0] lim_word;
    logic [BW-1:0] lim_bit;
    logic [LW-1:0] word_ext;
    logic [LW-1:0] word_inc;
    logic [WB-1:0] upper_mask;
    logic [WB-1:0] lower_mask;
    logic [WB-1:0] free_vec;
    logic          found;
    logic [BW-1:0] pos;
    logic          more_words;
    logic          scan_more;
    logic          final_eval;

    logic [1:0]    status_next;
    logic [PW-1:0] result_next;
    logic          wr_en;
    logic [WB-1:0] new_word;
    logic          used_inc;
    logic          used_dec;
    logic          resv_inc;
    logic          resv_dec;
    logic          hint_alloc;
    logic          hint_lower;
    logic [CW-1:0] free_count;

    // Page bit lookup for single-page commands
    assign bit_sel     = page_reg[BW-1:0];
    assign page_bit    = rdata_reg[bit_sel];
    assign page_onehot = {{(WB-1){1'b0}}, 1'b1} << bit_sel;
    assign in_range    = {1'b0, page_reg} < limit;

    // Valid-bit masks of the scanned word: below the limit, at or above hint
    assign lim_word = limit[CW-1:BW];
    assign lim_bit  = limit[BW-1:0];
    assign word_ext = {{(LW-AW){1'b0}}, word_reg};
    assign word_inc = word_ext + 1'b1;

    always_comb begin
        if (word_ext < lim_word) begin
            upper_mask = '1;
        end else if (word_ext == lim_word) begin
            upper_mask = ({{(WB-1){1'b0}}, 1'b1} << lim_bit) - 1'b1;
        end else begin
            upper_mask = '0;
        end
        if (first_reg) begin
            lower_mask = ~(({{(WB-1){1'b0}}, 1'b1} << hint_reg[BW-1:0]) - 1'b1);
        end else begin
            lower_mask = '1;
        end
    end

    assign free_vec = ~rdata_reg & upper_mask & lower_mask;
    assign found    = |free_vec;

    // Lowest free bit of the word
    always_comb begin
        pos = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                pos = BW'(b);
            end
        end
    end

    assign more_words = {word_inc, {BW{1'b0}}} < limit;
    assign scan_more  = (cmd_reg == bpa_pkg::CMD_ALLOC) && !found && more_words;
    assign final_eval = ctl.eval && !scan_more;

    // Command decision on the word just read
    always_comb begin
        status_next = bpa_pkg::STAT_NOCHANGE;
        result_next = page_reg;
        wr_en       = 1'b0;
        new_word    = rdata_reg;
        used_inc    = 1'b0;
        used_dec    = 1'b0;
        resv_inc    = 1'b0;
        resv_dec    = 1'b0;
        hint_alloc  = 1'b0;
        hint_lower  = 1'b0;
        case (cmd_reg)
            bpa_pkg::CMD_ALLOC: begin
                if (found) begin
                    status_next = bpa_pkg::STAT_DONE;
                    result_next = {word_reg, pos};
                    wr_en       = 1'b1;
                    new_word    = rdata_reg | ({{(WB-1){1'b0}}, 1'b1} << pos);
                    used_inc    = 1'b1;
                    hint_alloc  = 1'b1;
                end else begin
                    status_next = bpa_pkg::STAT_OOM;
                    result_next = '0;
                end
            end
            bpa_pkg::CMD_FREE, bpa_pkg::CMD_UNRESERVE: begin
                if (!in_range) begin
                    status_next = bpa_pkg::STAT_RANGE;
                end else begin
                    resv_dec = (cmd_reg == bpa_pkg::CMD_UNRESERVE);
                    if (page_bit) begin
                        status_next = bpa_pkg::STAT_DONE;
                        wr_en       = 1'b1;
                        new_word    = rdata_reg & ~page_onehot;
                        used_dec    = 1'b1;
                        hint_lower  = 1'b1;
                    end
                end
            end
            bpa_pkg::CMD_LOCK, bpa_pkg::CMD_RESERVE: begin
                if (!in_range) begin
                    status_next = bpa_pkg::STAT_RANGE;
                end else begin
                    resv_inc = (cmd_reg == bpa_pkg::CMD_RESERVE);
                    if (!page_bit) begin
                        status_next = bpa_pkg::STAT_DONE;
                        wr_en       = 1'b1;
                        new_word    = rdata_reg | page_onehot;
                        used_inc    = 1'b1;
                    end
                end
            end
            default: begin
                status_next = bpa_pkg::STAT_NOCHANGE;
            end
        endcase
    end

    // Memory port: clearing pass, scan read-ahead, or read-modify-write
    assign mem_addr  = (ctl.eval && scan_more) ? AW'(word_inc) : word_reg;
    assign mem_we    = ctl.clear || (final_eval && wr_en);
    assign mem_wdata = ctl.clear ? '0 : new_word;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= map_mem[mem_addr];
    end

    // Command capture and scan position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg  <= '0;
            first_reg <= 1'b0;
        end else if (ctl.clear) begin
            word_reg <= word_reg + 1'b1;
        end else if (ctl.accept) begin
            word_reg  <= (in_command == bpa_pkg::CMD_ALLOC) ? hint_reg[PW-1:BW]
                                                            : in_page[PW-1:BW];
            first_reg <= 1'b1;
        end else if (ctl.eval && scan_more) begin
            word_reg  <= AW'(word_inc);
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            cmd_reg  <= in_command;
            page_reg <= in_page;
        end
        if (final_eval) begin
            status_reg <= status_next;
            result_reg <= result_next;
        end
    end

    // Hint and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg <= '0;
            used_reg <= '0;
            resv_reg <= '0;
        end else if (final_eval) begin
            if (hint_alloc) begin
                hint_reg <= {word_reg, pos};
            end else if (hint_lower && (hint_reg > page_reg)) begin
                hint_reg <= page_reg;
            end
            if (used_inc) begin
                used_reg <= used_reg + 1'b1;
            end else if (used_dec && (used_reg != '0)) begin
                used_reg <= used_reg - 1'b1;
            end
            if (resv_inc && (resv_reg < CW'(bpa_pkg::RESERVE_MAX))) begin
                resv_reg <= resv_reg + 1'b1;
            end else if (resv_dec && (resv_reg != '0)) begin
                resv_reg <= resv_reg - 1'b1;
            end
        end
    end

    // Free pages, floored at zero when the limit was lowered
    assign free_count = (limit > used_reg) ? (limit - used_reg) : '0;

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            o_status_reg <= status_reg;
            o_page_reg   <= result_reg;
            o_free_reg   <= free_count;
            o_used_reg   <= used_reg;
            o_resv_reg   <= resv_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, o_resv_reg, o_used_reg, o_free_reg, o_page_reg, o_status_reg};

    assign sts.clear_done = (word_reg == AW'(bpa_pkg::MAP_WORDS - 1));
    assign sts.scan_more  = scan_more;
    assign sts.out_busy   = m_tvalid_reg && !m_tready;

endmodule

// ===== design/bitmap_page_allocator_core.sv =====
// Top level of the bitmap page allocator: APB register, limit clamp,
// and the controller/datapath pair.
// Depends on bpa_pkg, bpa_ctrl, bpa_dpath.
//
// Usage:
//  - Command stream in on s_tvalid/s_tready/s_tdata, one result per command
//    out on m_tvalid/m_tready/m_tdata. One command is in flight at a time.
//  - A command passes through capture, map read, evaluate/write and result
//    load. An allocate adds an evaluate step per extra 64-page map word it
//    scans past the hint; the single map memory port (one word read or
//    written per cycle) sets that pace.
//  - When the output register is free, the result is loaded after the capture,
//    read and evaluate states, and the next command is taken after that load.
//  - After reset (aresetn low, synchronous) the map is cleared one word per
//    cycle, all 1024 map words, with s_tready low. Configuration writes are taken
//    during that time. Hint and counts reset to zero, total_pages to 65536.
//  - If the receiver stalls, the result waits in the output register; the
//    next command is still taken and runs up to its result load, then waits.
//  - total_pages sits at APB address 0; write it only while no command is
//    in flight.
module bitmap_page_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [bpa_pkg::S_TDATA_W-1:0] s_tdata,  // [2:0] command, [18:3] page_index
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [17:2] result_page, [34:18] free_count,
    // [51:35] used_count, [68:52] reserved_count
    output logic [bpa_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic REG_TOTAL_PAGES = 1'b0;
    localparam int   CW = bpa_pkg::CNT_W;

    logic [CW-1:0]       total_pages_reg;
    logic [CW-1:0]       limit;
    logic                cfg_wr;
    bpa_pkg::bpa_cmd_t   ctl;
    bpa_pkg::bpa_stat_t  sts;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_pages_reg <= CW'(65536);
        end else if (cfg_wr && (paddr[2] == REG_TOTAL_PAGES)) begin
            total_pages_reg <= pwdata[CW-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOTAL_PAGES) ? {{(32-CW){1'b0}}, total_pages_reg}
                                                  : 32'd0;

    // Effective page limit
    assign limit = (total_pages_reg > CW'(bpa_pkg::LIMIT_MAX)) ? CW'(bpa_pkg::LIMIT_MAX)
                                                               : total_pages_reg;

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    bpa_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .in_command (s_tdata[2:0]),
        .in_page    (s_tdata[18:3]),
        .limit      (limit),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== design/bpa_checker.sv =====
// Port-level assertions for the bitmap page allocator, bound to the top.
// Depends on bpa_pkg and bitmap_page_allocator_core.
module bpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [bpa_pkg::M_TDATA_W-1:0] m_tdata
);

    // Stalled result stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Out of memory always reports page zero
    a_oom_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == bpa_pkg::STAT_OOM) |-> (m_tdata[17:2] == '0))
        else $error("out-of-memory result carries a page");

    // One command in flight: ready drops right after a command transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while one is in flight");

    // Reset empties the output and holds off commands for the clearing pass
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("channels active right after reset");

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
